// ===== rtl/mtd_pkg.sv =====
package mtd_pkg;

  localparam int MaxLetterSymbols = 15;
  localparam int CntW = $clog2(MaxLetterSymbols + 1);
  localparam int PatW = 5;
  localparam int CodeCount = 28;
  localparam int LetterCount = 26;

  localparam logic [7:0] ByteDot   = 8'h2E;
  localparam logic [7:0] ByteDash  = 8'h2D;
  localparam logic [7:0] ByteSpace = 8'h20;

  localparam logic [6:0] CharA       = 7'h41;
  localparam logic [6:0] CharZ       = 7'h5A;
  localparam logic [6:0] CharQmark   = 7'h3F;
  localparam logic [6:0] CharSpace   = 7'h20;
  localparam logic [6:0] CharNewline = 7'h0A;

  // code length and dash/dot bits per table entry, oldest symbol in the highest used bit
  localparam logic [2:0] CodeLen [CodeCount] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
    3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5
  };
  localparam logic [PatW-1:0] CodeBits [CodeCount] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4, 5'd3, 5'd2,
    5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12, 5'd0, 5'd31
  };

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [6:0] decoded_char;
    logic       message_end;
  } out_word_t;

  function automatic logic [6:0] match_code(logic [PatW-1:0] pat, logic [CntW-1:0] cnt);
    logic [6:0] ch;
    ch = CharQmark;
    if (cnt <= CntW'(PatW)) begin
      for (int i = CodeCount - 1; i >= 0; i--) begin
        if (CntW'(CodeLen[i]) == cnt && CodeBits[i] == pat) begin
          if (i < LetterCount) begin
            ch = CharA + 7'(i);
          end else if (i == LetterCount) begin
            ch = CharSpace;
          end else begin
            ch = CharNewline;
          end
        end
      end
    end
    return ch;
  endfunction

endpackage

// ===== rtl/morse_text_decoder.sv =====
// channel | direction | handshake               | word
// in      | input     | in_valid_i / in_stall_o   | in_word_t  (symbol_byte, end_of_message)
// out     | output    | out_valid_o / out_stall_i | out_word_t (decoded_char, message_end)
//
// One byte per cycle while in_stall_o is low. A byte that closes a character writes
// it to the output register, or to the skid register behind it while out is stalled.
// Letter state and that register update in the same cycle the byte is taken. The skid
// register absorbs one word; in_stall_o rises only when that skid register is full.
// Reset clears the letter state and both output valids.
module morse_text_decoder
  import mtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [PatW-1:0] pat_q, pat_d, pat_upd;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_upd;
  logic            inv_q, inv_d, inv_upd;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t skid_q, skid_d;

  logic      acc, take, is_space, is_sym, close_l, emit;
  out_word_t res;

  assign acc  = in_valid_i && !skid_valid_q;
  assign take = out_valid_q && !out_stall_i;

  assign is_space = in_word_i.symbol_byte == ByteSpace;
  assign is_sym   = in_word_i.symbol_byte == ByteDot || in_word_i.symbol_byte == ByteDash;

  always_comb begin
    pat_upd = pat_q;
    cnt_upd = cnt_q;
    inv_upd = inv_q;
    if (!is_space && cnt_q < CntW'(MaxLetterSymbols)) begin
      if (is_sym) begin
        if (cnt_q < CntW'(PatW)) begin
          pat_upd = {pat_q[PatW-2:0], in_word_i.symbol_byte == ByteDash};
        end
      end else begin
        inv_upd = 1'b1;
      end
      cnt_upd = cnt_q + CntW'(1);
    end
  end

  // a space leaves the state untouched, so closing always looks at the updated letter
  assign close_l = is_space || in_word_i.end_of_message;
  assign emit    = acc && close_l && cnt_upd != '0 && !inv_upd;
  assign res.decoded_char = match_code(pat_upd, cnt_upd);
  assign res.message_end  = in_word_i.end_of_message;

  always_comb begin
    pat_d = pat_q;
    cnt_d = cnt_q;
    inv_d = inv_q;
    if (acc) begin
      if (close_l) begin
        pat_d = '0;
        cnt_d = '0;
        inv_d = 1'b0;
      end else begin
        pat_d = pat_upd;
        cnt_d = cnt_upd;
        inv_d = inv_upd;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      cnt_q        <= '0;
      inv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pat_q        <= pat_d;
      cnt_q        <= cnt_d;
      inv_q        <= inv_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/mtd_checker.sv =====
module mtd_checker
  import mtd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // input backpressure only once the output side is occupied
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a fresh word comes from a byte taken the cycle before, with its end flag
  a_rise_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o)
      && out_word_o.message_end == $past(in_word_i.end_of_message))
    else $error("output word without matching input byte");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.decoded_char >= CharA && out_word_o.decoded_char <= CharZ)
      || out_word_o.decoded_char == CharSpace || out_word_o.decoded_char == CharNewline
      || out_word_o.decoded_char == CharQmark)
    else $error("illegal decoded character");

endmodule

bind morse_text_decoder mtd_checker u_mtd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
